### sv/assert_macros.svh
// Assertion helpers for the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property check failed");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

### sv/lcmc_pkg.sv
`default_nettype none

package lcmc_pkg;

   // Capacity register
   localparam int unsigned CAP_W = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Saturating miss counter
   localparam int unsigned MISS_W = 32;
   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   // Lookup engine sequencer
   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_MATCH,
      ENG_SELECT,
      ENG_UPDATE
   } eng_state_type;

endpackage

`default_nettype wire

### sv/lcmc_queue.sv
`default_nettype none

module lcmc_queue #(
   parameter int unsigned ID_W = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [ID_W-1:0] in_id,
   output logic                 out_valid,
   input  wire logic            out_pop,
   output logic [ID_W-1:0]      out_id
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   logic [ID_W-1:0] entry_ff [2];
   logic            wr_ptr_ff;
   logic            wr_ptr_in;
   logic            rd_ptr_ff;
   logic            rd_ptr_in;
   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   logic            push;
   logic            pop;

   // Accept while a slot is free; hand the oldest item to the engine
   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != 2'd0);
   assign out_id    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_id;
      end
   end

endmodule

`default_nettype wire

### sv/lcmc_engine.sv
`default_nettype none
`include "assert_macros.svh"

module lcmc_engine
   import lcmc_pkg::*;
#(
   parameter int unsigned MAX_LINES = 64,
   parameter int unsigned ID_W      = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CAP_W-1:0] capacity,
   input  wire logic             q_valid,
   input  wire logic [ID_W-1:0]  q_id,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_hit,
   output logic [MISS_W-1:0]     rsp_miss_total,
   output logic                  rsp_evicted_valid,
   output logic [ID_W-1:0]       rsp_evicted_block
);

   localparam int unsigned RANK_W = $clog2(MAX_LINES);
   localparam int unsigned CNT_W  = $clog2(MAX_LINES + 1);
   localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [MAX_LINES-1:0] ONE_VEC = 1;

   eng_state_type state_ff;
   eng_state_type state_in;

   // Line array
   logic [ID_W-1:0]      tag_ff   [MAX_LINES];
   logic [MAX_LINES-1:0] valid_ff;
   logic [MAX_LINES-1:0] valid_in;
   logic [RANK_W-1:0]    rank_ff  [MAX_LINES];
   logic [RANK_W-1:0]    rank_in  [MAX_LINES];
   logic [MAX_LINES-1:0] tag_we;
   logic [CNT_W-1:0]     occ_ff;
   logic [CNT_W-1:0]     occ_in;
   logic [MISS_W-1:0]    miss_ff;
   logic [MISS_W-1:0]    miss_in;

   // Per-item working registers
   logic [ID_W-1:0]      id_ff;
   logic [MAX_LINES-1:0] hit_vec_ff;
   logic [MAX_LINES-1:0] lru_vec_ff;
   logic [MAX_LINES-1:0] free_vec_ff;
   logic                 hit_ff;
   logic [RANK_W-1:0]    found_rank_ff;
   logic                 evict_ff;
   logic [ID_W-1:0]      evict_tag_ff;
   logic [MAX_LINES-1:0] slot_vec_ff;

   // Match stage
   logic [MAX_LINES-1:0] hit_vec_c;
   logic [MAX_LINES-1:0] lru_vec_c;
   logic [MAX_LINES-1:0] free_c;
   logic [MAX_LINES-1:0] free_vec_c;
   logic [RANK_W-1:0]    lru_rank;

   // Select stage
   logic                 in_select;
   logic                 hit_c;
   logic [RANK_W-1:0]    found_rank_c;
   logic [ID_W-1:0]      evict_tag_c;
   logic                 evict_c;
   logic [CMP_W-1:0]     cap_ext;
   logic [CMP_W-1:0]     eff_cap;
   logic                 full_c;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [MISS_W-1:0]    rsp_miss_total_ff;
   logic                 rsp_evicted_valid_ff;
   logic [ID_W-1:0]      rsp_evicted_block_ff;
   logic                 out_free;
   logic                 commit;
   logic [MISS_W-1:0]    miss_next;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_miss_total    = rsp_miss_total_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_block = rsp_evicted_block_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ENG_UPDATE) && out_free;
   assign in_select = (state_ff == ENG_SELECT);

   // Sequence one item through match, select and update
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ENG_MATCH;
            end
         end
         ENG_MATCH: begin
            state_in = ENG_SELECT;
         end
         ENG_SELECT: begin
            state_in = ENG_UPDATE;
         end
         ENG_UPDATE: begin
            if (out_free) begin
               if (q_valid) begin
                  q_pop    = 1'b1;
                  state_in = ENG_MATCH;
               end else begin
                  state_in = ENG_IDLE;
               end
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the popped block id
   always_ff @(posedge clock) begin
      if (q_pop) begin
         id_ff <= q_id;
      end
   end

   // Compare every line in parallel; find the oldest and a free line
   assign lru_rank   = RANK_W'(occ_ff - 1'b1);
   assign free_c     = ~valid_ff;
   assign free_vec_c = free_c & (~free_c + ONE_VEC);

   always_comb begin
      for (int i = 0; i < MAX_LINES; i++) begin
         hit_vec_c[i] = valid_ff[i] && (tag_ff[i] == id_ff);
         lru_vec_c[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ENG_MATCH) begin
         hit_vec_ff  <= hit_vec_c;
         lru_vec_ff  <= lru_vec_c;
         free_vec_ff <= free_vec_c;
      end
   end

   // Reduce the one-hot vectors to the hit rank and the victim tag
   always_comb begin
      found_rank_c = '0;
      evict_tag_c  = '0;
      for (int i = 0; i < MAX_LINES; i++) begin
         found_rank_c = found_rank_c | ({RANK_W{hit_vec_ff[i]}} & rank_ff[i]);
         evict_tag_c  = evict_tag_c | ({ID_W{lru_vec_ff[i]}} & tag_ff[i]);
      end
   end

   // Clamp capacity to one line at least and the array size at most
   assign cap_ext = CMP_W'(capacity);
   always_comb begin
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_LINES)) begin
         eff_cap = CMP_W'(MAX_LINES);
      end
   end

   assign full_c  = (CMP_W'(occ_ff) >= eff_cap);
   assign hit_c   = |hit_vec_ff;
   assign evict_c = !hit_c && full_c;

   always_ff @(posedge clock) begin
      if (state_ff == ENG_SELECT) begin
         hit_ff        <= hit_c;
         found_rank_ff <= found_rank_c;
         evict_ff      <= evict_c;
         evict_tag_ff  <= evict_tag_c;
         slot_vec_ff   <= evict_c ? lru_vec_ff : free_vec_ff;
      end
   end

   // Update recency, validity and tags of every line
   always_comb begin
      for (int i = 0; i < MAX_LINES; i++) begin
         rank_in[i]  = rank_ff[i];
         valid_in[i] = valid_ff[i];
         tag_we[i]   = 1'b0;
         if (commit) begin
            if (hit_ff) begin
               if (hit_vec_ff[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < found_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end else if (slot_vec_ff[i]) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
               tag_we[i]   = 1'b1;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   // Count misses and lines in use
   assign miss_next = (miss_ff == MISS_MAX) ? miss_ff : miss_ff + 1'b1;

   always_comb begin
      miss_in = miss_ff;
      occ_in  = occ_ff;
      if (commit && !hit_ff) begin
         miss_in = miss_next;
         if (!evict_ff) begin
            occ_in = occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         miss_ff  <= '0;
         for (int i = 0; i < MAX_LINES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         miss_ff  <= miss_in;
         for (int i = 0; i < MAX_LINES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LINES; i++) begin
         if (tag_we[i]) begin
            tag_ff[i] <= id_ff;
         end
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff           <= hit_ff;
         rsp_miss_total_ff    <= hit_ff ? miss_ff : miss_next;
         rsp_evicted_valid_ff <= evict_ff;
         rsp_evicted_block_ff <= evict_ff ? evict_tag_ff : '0;
      end
   end

   `ASSERT_PROP(a_hit_unique, clock, reset, (state_ff == ENG_SELECT) |-> $onehot0(hit_vec_ff))
   `ASSERT_PROP(a_lru_unique, clock, reset, (in_select && (occ_ff != '0)) |-> $onehot(lru_vec_ff))
   `ASSERT_PROP(a_occ_matches, clock, reset, $countones(valid_ff) == occ_ff)
   `ASSERT_NEVER(a_occ_bound, clock, reset, occ_ff > CNT_W'(MAX_LINES))

endmodule

`default_nettype wire

### sv/lru_cache_miss_counter_unit.sv
// A result is registered once its item has passed through the queue and the match, select and
// update steps; the engine takes no new item until the last is committed, as these steps
// share the single line array of the lookup engine; a 2-entry queue decouples input.
// Reset: synchronous, active high; empties every line, clears the miss count and
// occupancy, and sets the capacity register to 64. No clearing pass is needed.
`default_nettype none

module lru_cache_miss_counter_unit
   import lcmc_pkg::*;
#(
   parameter int unsigned MAX_LINES     = 64,
   parameter int unsigned BLOCK_ID_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [BLOCK_ID_BITS-1:0] req_block_id,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_hit,
   output logic [MISS_W-1:0]             rsp_miss_total,
   output logic                          rsp_evicted_valid,
   output logic [BLOCK_ID_BITS-1:0]      rsp_evicted_block,
   input  wire logic                     csr_write_enable,
   input  wire logic [CAP_W-1:0]         csr_write_data
);

   logic [CAP_W-1:0]         capacity_ff;
   logic [CAP_W-1:0]         capacity_in;
   logic                     q_valid;
   logic                     q_pop;
   logic [BLOCK_ID_BITS-1:0] q_id;

   // Capacity register
   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Front: accept and buffer items
   lcmc_queue #(
      .ID_W (BLOCK_ID_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_id     (req_block_id),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_id    (q_id)
   );

   // Back: look up, replace and report
   lcmc_engine #(
      .MAX_LINES (MAX_LINES),
      .ID_W      (BLOCK_ID_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .capacity          (capacity_ff),
      .q_valid           (q_valid),
      .q_id              (q_id),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_miss_total    (rsp_miss_total),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_block (rsp_evicted_block)
   );

endmodule

`default_nettype wire

### tb/sv/lru_cache_miss_counter_unit_test.sv
`timescale 1ns / 100ps

module lru_cache_miss_counter_unit_test
   import lcmc_pkg::*;
();

   localparam int LINES = 64;
   localparam int ID_W  = 16;

   // One result item as the block reports it
   typedef struct packed {
      logic                  hit;
      logic [MISS_W-1:0]     miss_total;
      logic                  evicted_valid;
      logic [ID_W-1:0]       evicted_block;
   } access_outcome_type;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [ID_W-1:0]   req_block_id      = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic              rsp_hit;
   logic [MISS_W-1:0] rsp_miss_total;
   logic              rsp_evicted_valid;
   logic [ID_W-1:0]   rsp_evicted_block;
   logic              csr_write_enable  = 1'b0;
   logic [CAP_W-1:0]  csr_write_data    = '0;

   // Stimulus and scoreboard storage
   logic [ID_W-1:0]    pending_ids[$];
   access_outcome_type awaited_outcomes[$];
   int                 mismatch_count = 0;
   int                 src_gap        = 0;
   int                 sink_gap       = 0;
   bit                 idle_enable    = 1'b1;

   // Shadow copy of the cache contents
   logic [ID_W-1:0]   line_id   [LINES];
   bit                line_live [LINES];
   int unsigned       line_age  [LINES];
   int unsigned       fill_count     = 0;
   logic [MISS_W-1:0] miss_tally     = '0;
   logic [CAP_W-1:0]  model_capacity = CAP_RESET;

   lru_cache_miss_counter_unit #(
      .MAX_LINES    (LINES),
      .BLOCK_ID_BITS(ID_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_block_id     (req_block_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_miss_total   (rsp_miss_total),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_block(rsp_evicted_block),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Work out the outcome of one access and advance the shadow cache
   function automatic access_outcome_type predict_access(logic [ID_W-1:0] id);
      access_outcome_type r;
      int          hit_line;
      int          victim;
      int unsigned eff_cap;
      int unsigned oldest;
      r        = '0;
      hit_line = -1;
      victim   = -1;
      oldest   = 0;
      if (model_capacity == 0)
         eff_cap = 1;
      else if (model_capacity > LINES)
         eff_cap = LINES;
      else
         eff_cap = model_capacity;

      for (int i = 0; i < LINES; i++)
         if (hit_line < 0 && line_live[i] && line_id[i] == id)
            hit_line = i;

      // Hit: promote the line, age only those more recent than it
      if (hit_line >= 0) begin
         for (int i = 0; i < LINES; i++)
            if (i != hit_line && line_live[i] && line_age[i] < line_age[hit_line])
               line_age[i]++;
         line_age[hit_line] = 0;
         r.hit        = 1'b1;
         r.miss_total = miss_tally;
         return r;
      end

      if (miss_tally != MISS_MAX)
         miss_tally++;

      // Full (or over a lowered capacity): drop exactly one oldest line
      if (fill_count >= eff_cap) begin
         for (int i = 0; i < LINES; i++)
            if (line_live[i] && (victim < 0 || line_age[i] > oldest)) begin
               oldest = line_age[i];
               victim = i;
            end
         if (victim >= 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_block = line_id[victim];
            line_live[victim] = 1'b0;
            fill_count--;
         end
      end
      if (victim < 0)
         for (int i = 0; i < LINES; i++)
            if (victim < 0 && !line_live[i])
               victim = i;

      // Insert the new block as the most recent
      if (victim >= 0) begin
         for (int i = 0; i < LINES; i++)
            if (i != victim && line_live[i])
               line_age[i]++;
         line_id[victim]   = id;
         line_live[victim] = 1'b1;
         line_age[victim]  = 0;
         fill_count++;
      end
      r.miss_total = miss_tally;
      return r;
   endfunction

   // Append one block id to the stimulus queue
   function automatic void add_pending(logic [ID_W-1:0] id);
      pending_ids = {pending_ids, id};
   endfunction

   task automatic flag_mismatch(string field, logic [MISS_W-1:0] want, logic [MISS_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0h, got %0h", field, want, got);
   endtask

   // Hold until every queued item is sent and every result has come back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_ids.size() != 0 || req_valid || awaited_outcomes.size() != 0);
   endtask

   // Write the capacity register while the block is idle
   task automatic set_capacity(logic [CAP_W-1:0] value, bit with_idling);
      wait_until_drained();
      idle_enable = with_idling;
      repeat (16) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_capacity = value;
   endtask

   // Draw mostly from a small set of ids so that hits and evictions mix
   task automatic queue_accesses(int count, int pool_size);
      logic [ID_W-1:0] pool[$];
      for (int k = 0; k < pool_size; k++)
         pool = {pool, ID_W'($urandom)};
      for (int k = 0; k < count; k++)
         if ($urandom_range(0, 99) < 85)
            add_pending(pool[$urandom_range(0, pool_size - 1)]);
         else
            add_pending(ID_W'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drive the access channel; predict each item as it is accepted
   always @(posedge clock) begin : drive_req
      bit busy;
      if (reset) begin
         req_valid <= 1'b0;
         src_gap   <= 0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            awaited_outcomes = {awaited_outcomes, predict_access(req_block_id)};
            busy = 1'b0;
         end
         if (!busy) begin
            if (src_gap > 0) begin
               src_gap   <= src_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ids.size() != 0) begin
               req_valid    <= 1'b1;
               req_block_id <= pending_ids.pop_front();
               if (idle_enable && $urandom_range(0, 7) == 0)
                  src_gap <= $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result item against the oldest prediction; stall at random
   always @(posedge clock) begin : watch_rsp
      access_outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result item with none outstanding: hit %0b miss_total %0h",
                           rsp_hit, rsp_miss_total);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_hit !== want.hit)
                  flag_mismatch("hit", want.hit, rsp_hit);
               if (rsp_miss_total !== want.miss_total)
                  flag_mismatch("miss_total", want.miss_total, rsp_miss_total);
               if (rsp_evicted_valid !== want.evicted_valid)
                  flag_mismatch("evicted_valid", want.evicted_valid, rsp_evicted_valid);
               if (rsp_evicted_block !== want.evicted_block)
                  flag_mismatch("evicted_block", want.evicted_block, rsp_evicted_block);
            end
         end
         if (sink_gap > 0) begin
            sink_gap  <= sink_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            sink_gap  <= $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int cap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Capacity zero behaves as one: once the single line is filled, every miss displaces it
      set_capacity(7'd0, 1'b1);
      add_pending(16'h0000); add_pending(16'hFFFF);
      add_pending(16'hFFFF); add_pending(16'h0000);
      add_pending(16'h0001); add_pending(16'h0001);

      // Small cache: fill, hit to reorder, then miss to evict the oldest
      set_capacity(7'd3, 1'b1);
      add_pending(16'hAAAA); add_pending(16'h5555);
      add_pending(16'h0001); add_pending(16'h8000);
      add_pending(16'hAAAA); add_pending(16'h5555);
      add_pending(16'h8000); add_pending(16'h1234);

      // Capacity lowered below occupancy: one eviction per later miss only
      set_capacity(7'd1, 1'b1);
      add_pending(16'h7FFF); add_pending(16'hFFFE);
      add_pending(16'h7FFF); add_pending(16'h0002);

      // Capacity above the line count is clamped to the full array
      set_capacity(7'd127, 1'b1);
      queue_accesses(150, 80);

      set_capacity(7'd2, 1'b1);
      queue_accesses(70, 5);

      cap = $urandom_range(1, 64);
      set_capacity(CAP_W'(cap), 1'b1);
      queue_accesses(80, cap + $urandom_range(1, 8));

      set_capacity(7'd64, 1'b1);
      queue_accesses(100, 72);

      // Final stretch at full rate with a lowered capacity
      set_capacity(7'd16, 1'b0);
      queue_accesses(100, 22);

      wait_until_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && awaited_outcomes.size() == 0)
         $display("lru_cache_miss_counter_unit regression: pass");
      else
         $display("lru_cache_miss_counter_unit regression: fail");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("lru_cache_miss_counter_unit regression: fail");
      $finish;
   end

endmodule
